[rtl/ghd_pkg.sv]
// Package for the grid heat diffusion block: field widths, action and
// register codes, and the fixed-point constants of the diffusion datapath.
// No dependencies.
package ghd_pkg;

  localparam int LEVEL_W = 16;
  typedef logic signed [LEVEL_W-1:0] level_t;

  localparam int ACTION_W = 2;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int RATE_W  = 9;
  localparam logic [RATE_W-1:0] RATE_ONE = 9'd256;

  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_AMBIENT     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIFF_RATE   = 2'd3;

  // Datapath widths: neighbor sum, gap to the mean, gap times rate, quotient.
  localparam int CNT_W  = 3;
  localparam int SUM_W  = 18;
  localparam int DIFF_W = 19;
  localparam int PROD_W = 28;
  localparam int QUOT_W = 18;

  // Floor division by three of a biased, non-negative value below 2**20.
  localparam int DIV3_IN_W    = 20;
  localparam int RECIP3_W     = 21;
  localparam logic [RECIP3_W-1:0] RECIP3 = 21'd1398102;
  localparam int RECIP3_SHIFT = 22;
  localparam int MUL_W        = DIV3_IN_W + RECIP3_W;
  localparam int DIV3_BIAS    = 786432;
  localparam int DIV3_OFS     = 262144;
  localparam int DELTA_W      = 20;

endpackage

[rtl/ghd_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write of the same entry in one cycle return the old data.
// No dependencies.
module ghd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ghd_stencil.sv]
// Tick engine: streams the current bank in raster order, keeps two rows in
// line buffers and writes every cell, updated or unchanged, into the other bank.
// Depends on ghd_pkg and ghd_ram.
module ghd_stencil #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]              eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]             eff_h,
  input  logic [ghd_pkg::RATE_W-1:0]                  rate,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     rd_addr,
  input  ghd_pkg::level_t                             rd_data,
  output logic                                        wr_en,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]     wr_addr,
  output ghd_pkg::level_t                             wr_data,
  output logic                                        done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    E_IDLE  = 3'b001,
    E_RUN   = 3'b010,
    E_DRAIN = 3'b100
  } eng_state_t;

  eng_state_t state;
  logic [CW-1:0] a_tx;
  logic [RW-1:0] a_ty;
  logic a_valid;

  logic b_valid, c_valid, d_valid, e_valid, f_valid, g_valid;
  logic [CW-1:0] b_tx;
  logic [RW-1:0] b_ty;

  ghd_pkg::level_t lb1_q, lb2_q;
  ghd_pkg::level_t m1, m2, d1, u1;

  logic [CW-1:0] ctr_x;
  logic [YW-1:0] ctr_y;
  logic ctr_ok;

  ghd_pkg::level_t c_right, c_center, c_left, c_down, c_up;
  logic [CW-1:0] c_cx;
  logic [YW-1:0] c_cy;

  logic has_r, has_l, has_d, has_u, in_grid;
  logic signed [ghd_pkg::SUM_W-1:0] sum;
  logic [ghd_pkg::CNT_W-1:0] cnt;

  logic signed [ghd_pkg::SUM_W-1:0] d_sum;
  logic [ghd_pkg::CNT_W-1:0] d_cnt, e_cnt, f_cnt;
  logic d_upd, e_upd, f_upd, g_upd;
  ghd_pkg::level_t d_old, e_old, f_old, g_old;
  logic [AW-1:0] d_addr, e_addr, f_addr, g_addr;

  logic signed [ghd_pkg::DIFF_W-1:0] old_scaled;
  logic signed [ghd_pkg::DIFF_W-1:0] e_diff;
  logic signed [ghd_pkg::DIFF_W+ghd_pkg::RATE_W:0] prod_full;
  logic signed [ghd_pkg::PROD_W-1:0] f_prod;

  logic signed [ghd_pkg::PROD_W-1:0] sh8, sh9, sh10, biased;
  logic signed [ghd_pkg::QUOT_W-1:0] quot;
  logic [ghd_pkg::MUL_W-1:0] g_mul;
  logic signed [ghd_pkg::QUOT_W-1:0] g_quot;
  logic g_three;

  logic signed [ghd_pkg::DELTA_W-1:0] delta, new_val;

  assign a_valid = (state == E_RUN);
  assign rd_addr = AW'(32'(a_ty) * MAX_WIDTH + 32'(a_tx));
  assign done = (state == E_DRAIN) &&
                !(b_valid || c_valid || d_valid || e_valid || f_valid || g_valid);

  // Line buffers: lb1 delays the stream by one row, lb2 by two rows.
  ghd_ram #(.WIDTH(ghd_pkg::LEVEL_W), .DEPTH(MAX_WIDTH)) u_line_1 (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_tx),
    .wdata (rd_data),
    .raddr (a_tx),
    .rdata (lb1_q)
  );

  ghd_ram #(.WIDTH(ghd_pkg::LEVEL_W), .DEPTH(MAX_WIDTH)) u_line_2 (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_tx),
    .wdata (lb1_q),
    .raddr (a_tx),
    .rdata (lb2_q)
  );

  // The center cell lies one row and one column behind the newest cell.
  always_comb begin
    if (b_tx != '0) begin
      ctr_x  = b_tx - 1'b1;
      ctr_y  = YW'(b_ty - RW'(1));
      ctr_ok = (b_ty != '0);
    end else begin
      ctr_x  = LAST_COL;
      ctr_y  = YW'(b_ty - RW'(2));
      ctr_ok = (b_ty > RW'(1));
    end
  end

  always_comb begin
    in_grid = (32'(c_cx) < 32'(eff_w)) && (32'(c_cy) < 32'(eff_h));
    has_r   = (32'(c_cx) + 1 < 32'(eff_w));
    has_l   = (c_cx != '0);
    has_d   = (32'(c_cy) + 1 < 32'(eff_h));
    has_u   = (c_cy != '0);
    sum = (has_r ? ghd_pkg::SUM_W'(c_right) : '0) +
          (has_l ? ghd_pkg::SUM_W'(c_left)  : '0) +
          (has_d ? ghd_pkg::SUM_W'(c_down)  : '0) +
          (has_u ? ghd_pkg::SUM_W'(c_up)    : '0);
    cnt = ghd_pkg::CNT_W'(has_r) + ghd_pkg::CNT_W'(has_l) +
          ghd_pkg::CNT_W'(has_d) + ghd_pkg::CNT_W'(has_u);
  end

  always_comb begin
    unique case (d_cnt)
      3'd1:    old_scaled = ghd_pkg::DIFF_W'(d_old);
      3'd2:    old_scaled = ghd_pkg::DIFF_W'(d_old) <<< 1;
      3'd3:    old_scaled = ghd_pkg::DIFF_W'(d_old) + (ghd_pkg::DIFF_W'(d_old) <<< 1);
      3'd4:    old_scaled = ghd_pkg::DIFF_W'(d_old) <<< 2;
      default: old_scaled = '0;
    endcase
  end

  assign prod_full = e_diff * $signed({1'b0, rate});

  always_comb begin
    sh8    = f_prod >>> 8;
    sh9    = f_prod >>> 9;
    sh10   = f_prod >>> 10;
    biased = sh8 + ghd_pkg::PROD_W'(ghd_pkg::DIV3_BIAS);
    unique case (f_cnt)
      3'd2:    quot = ghd_pkg::QUOT_W'(sh9);
      3'd4:    quot = ghd_pkg::QUOT_W'(sh10);
      default: quot = ghd_pkg::QUOT_W'(sh8);
    endcase
  end

  always_comb begin
    if (g_three) begin
      delta = $signed({1'b0, g_mul[ghd_pkg::MUL_W-1:ghd_pkg::RECIP3_SHIFT]}) -
              ghd_pkg::DELTA_W'(ghd_pkg::DIV3_OFS);
    end else begin
      delta = ghd_pkg::DELTA_W'(g_quot);
    end
    new_val = ghd_pkg::DELTA_W'(g_old) + delta;
  end

  assign wr_en   = g_valid;
  assign wr_addr = g_addr;
  assign wr_data = g_upd ? new_val[ghd_pkg::LEVEL_W-1:0] : g_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= E_IDLE;
      a_tx    <= '0;
      a_ty    <= '0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
      c_valid <= b_valid && ctr_ok;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            a_tx  <= '0;
            a_ty  <= '0;
            state <= E_RUN;
          end
        end
        E_RUN: begin
          if (a_tx == '0 && a_ty == LAST_ROW) begin
            state <= E_DRAIN;
          end else if (a_tx == LAST_COL) begin
            a_tx <= '0;
            a_ty <= a_ty + 1'b1;
          end else begin
            a_tx <= a_tx + 1'b1;
          end
        end
        E_DRAIN: begin
          if (done) begin
            state <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    b_tx <= a_tx;
    b_ty <= a_ty;
    if (b_valid) begin
      m1 <= lb1_q;
      m2 <= m1;
      d1 <= rd_data;
      u1 <= lb2_q;
    end
    c_right  <= lb1_q;
    c_center <= m1;
    c_left   <= m2;
    c_down   <= d1;
    c_up     <= u1;
    c_cx     <= ctr_x;
    c_cy     <= ctr_y;

    d_sum  <= sum;
    d_cnt  <= cnt;
    d_upd  <= in_grid && (cnt != '0);
    d_old  <= c_center;
    d_addr <= AW'(32'(c_cy) * MAX_WIDTH + 32'(c_cx));

    e_diff <= ghd_pkg::DIFF_W'(d_sum) - old_scaled;
    e_cnt  <= d_cnt;
    e_upd  <= d_upd;
    e_old  <= d_old;
    e_addr <= d_addr;

    f_prod <= prod_full[ghd_pkg::PROD_W-1:0];
    f_cnt  <= e_cnt;
    f_upd  <= e_upd;
    f_old  <= e_old;
    f_addr <= e_addr;

    g_mul   <= biased[ghd_pkg::DIV3_IN_W-1:0] * ghd_pkg::RECIP3;
    g_quot  <= quot;
    g_three <= (f_cnt == 3'd3);
    g_upd   <= f_upd;
    g_old   <= f_old;
    g_addr  <= f_addr;
  end

endmodule

[rtl/grid_heat_diffusion_step.sv]
// Top level of the grid heat diffusion block: configuration registers,
// command handling, the two cell banks and the output register.
// Depends on ghd_pkg, ghd_ram and ghd_stencil.
//
// Usage: commands arrive on the s_ channel, one result per command leaves on
// the m_ channel. s_tuser carries the action (write, read, tick); s_tdata
// carries column, row and level. m_tdata is the read level, m_tuser the
// in-range flag. Registers are written through cfg_we, cfg_index, cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// A write returns its result in the cycle after its transfer; a read passes
// through the S_READ state and the output register. A tick streams the full
// MAX_WIDTH x MAX_HEIGHT bank through one read port, one cell per cycle.
// One command is processed at a time; a new command is taken once the
// previous one is finished and the output register is empty or being drained.
// When the receiver stalls, the result holds in the output register and no
// further command is taken. Reset clears the registers to their defaults and
// selects bank A; cell contents are undefined until written.
module grid_heat_diffusion_step #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ghd_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [ghd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // col[5:0], row[11:6], level[27:12]
  input  logic [ghd_pkg::ACTION_W-1:0]    s_tuser,   // action[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // read_level[15:0]
  output logic [0:0]                      m_tuser    // in_range[0]
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int EH = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_TICK = 3'b100
  } state_t;

  state_t state, state_next;

  logic [ghd_pkg::DIM_W-1:0]  grid_width, grid_height;
  ghd_pkg::level_t            ambient_level;
  logic [ghd_pkg::RATE_W-1:0] diffusion_rate;

  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;
  logic [ghd_pkg::RATE_W-1:0] rate_eff;

  logic [ghd_pkg::COORD_W-1:0] col, row;
  ghd_pkg::level_t level;
  logic [ghd_pkg::ACTION_W-1:0] action;
  logic accept, in_grid, norm_we, rd_hit, bank_select;
  logic [AW-1:0] req_addr, rd_addr, w_addr;
  ghd_pkg::level_t w_data, qa, qb, cur_q;
  logic wa_en, wb_en;

  logic tick_start, tick_done, eng_we;
  logic [AW-1:0] eng_rd_addr, eng_wr_addr;
  ghd_pkg::level_t eng_wr_data;

  logic out_load, out_flag;
  ghd_pkg::level_t out_level;

  assign col    = s_tdata[5:0];
  assign row    = s_tdata[11:6];
  assign level  = s_tdata[27:12];
  assign action = s_tuser;

  always_comb begin
    if (grid_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = EH'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(grid_height);
    end
    rate_eff = (diffusion_rate > ghd_pkg::RATE_ONE) ? ghd_pkg::RATE_ONE : diffusion_rate;
  end

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign in_grid  = (32'(col) < 32'(eff_w)) && (32'(row) < 32'(eff_h));
  assign req_addr = AW'(32'(row) * MAX_WIDTH + 32'(col));
  assign norm_we  = accept && (action == ghd_pkg::ACT_WRITE) && in_grid;

  assign cur_q   = bank_select ? qb : qa;
  assign rd_addr = (state == S_TICK) ? eng_rd_addr : req_addr;
  assign wa_en   = (norm_we && !bank_select) || (eng_we && bank_select);
  assign wb_en   = (norm_we && bank_select) || (eng_we && !bank_select);
  assign w_addr  = eng_we ? eng_wr_addr : req_addr;
  assign w_data  = eng_we ? eng_wr_data : level;

  ghd_ram #(.WIDTH(ghd_pkg::LEVEL_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_bank_a (
    .clk   (clk),
    .we    (wa_en),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (rd_addr),
    .rdata (qa)
  );

  ghd_ram #(.WIDTH(ghd_pkg::LEVEL_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_bank_b (
    .clk   (clk),
    .we    (wb_en),
    .waddr (w_addr),
    .wdata (w_data),
    .raddr (rd_addr),
    .rdata (qb)
  );

  ghd_stencil #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_stencil (
    .clk     (clk),
    .rst     (rst),
    .start   (tick_start),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .rate    (rate_eff),
    .rd_addr (eng_rd_addr),
    .rd_data (cur_q),
    .wr_en   (eng_we),
    .wr_addr (eng_wr_addr),
    .wr_data (eng_wr_data),
    .done    (tick_done)
  );

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_level  = '0;
    out_flag   = 1'b0;
    tick_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ghd_pkg::ACT_WRITE: begin
              out_load = 1'b1;
              out_flag = in_grid;
            end
            ghd_pkg::ACT_READ: begin
              state_next = S_READ;
            end
            ghd_pkg::ACT_TICK: begin
              tick_start = 1'b1;
              state_next = S_TICK;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_load   = 1'b1;
        out_level  = rd_hit ? cur_q : ambient_level;
        out_flag   = rd_hit;
        state_next = S_IDLE;
      end
      S_TICK: begin
        if (tick_done) begin
          out_load   = 1'b1;
          out_flag   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      bank_select    <= 1'b0;
      grid_width     <= ghd_pkg::DIM_W'(64);
      grid_height    <= ghd_pkg::DIM_W'(64);
      ambient_level  <= '0;
      diffusion_rate <= ghd_pkg::RATE_W'(26);
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (tick_done) begin
        bank_select <= !bank_select;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ghd_pkg::REG_GRID_WIDTH:  grid_width     <= cfg_data[ghd_pkg::DIM_W-1:0];
          ghd_pkg::REG_GRID_HEIGHT: grid_height    <= cfg_data[ghd_pkg::DIM_W-1:0];
          ghd_pkg::REG_AMBIENT:     ambient_level  <= cfg_data[ghd_pkg::LEVEL_W-1:0];
          ghd_pkg::REG_DIFF_RATE:   diffusion_rate <= cfg_data[ghd_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hit <= in_grid;
    end
    if (out_load) begin
      m_tdata    <= out_level;
      m_tuser[0] <= out_flag;
    end
  end

endmodule
